[rtl/core/rrtsm_pkg.sv]
// ---------------------------------------------------------------------------
// Round-robin tagged stream merger package
// Status codes, fixed field widths and parameter defaults shared by the
// merger and its port checker.
// ---------------------------------------------------------------------------
`default_nettype none

package rrtsm_pkg;

  // Parameter defaults.
  localparam int SOURCES_DEF     = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int WORD_WIDTH_DEF  = 64;

  // The source tag sits this many bits below the top of the word.
  localparam int HEADER_BITS = 32;

  // Fixed field widths of the stream ports.
  localparam int ITEM_DATA_W = 64;
  localparam int MERGED_W    = 64;
  localparam int SRC_TAG_W   = 2;
  localparam int STATUS_W    = 3;

  localparam int S_TDATA_W = 64;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 72;
  localparam int M_TUSER_W = STATUS_W;
  localparam int M_PAD_W   = M_TDATA_W - MERGED_W - SRC_TAG_W;

  // Result status of one request.
  typedef enum logic [STATUS_W-1:0] {
    ST_STORED  = 3'd0,
    ST_NODATA  = 3'd1,
    ST_DROPPED = 3'd2,
    ST_MERGED  = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_ORDER   = 3'd5
  } status_e;

endpackage

`default_nettype wire

[rtl/core/round_robin_tagged_stream_merger.sv]
// ---------------------------------------------------------------------------
// Round-robin tagged stream merger
// Per-source FIFOs in one word memory, with head and fill counts in a small
// metadata memory, merged out in round-robin order with a source tag.
// ---------------------------------------------------------------------------
// The block handles one request at a time. A request is taken in the idle
// state and its result is loaded into the output register from the execute
// state for a slot without data, an out-of-order merge or a merge with all
// FIFOs empty, after one metadata memory read for a stored or dropped word,
// and after a metadata read, then a word memory read, for a merged word.
// The next request is taken in the cycle after that. A result waiting in
// the output register holds a later request only at the point where that
// request's own result must be loaded. The FIFOs need no clearing pass: an
// empty FIFO is tracked by a flag that reset clears, and its metadata then
// reads as zero.
`default_nettype none

module round_robin_tagged_stream_merger #(
  parameter int SOURCES     = rrtsm_pkg::SOURCES_DEF,
  parameter int QUEUE_DEPTH = rrtsm_pkg::QUEUE_DEPTH_DEF,
  parameter int WORD_WIDTH  = rrtsm_pkg::WORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // item_data [63:0]
  input  logic [rrtsm_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // command [0], has_data [1]
  input  logic [rrtsm_pkg::S_TUSER_W-1:0] s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // merged_word [63:0], source_index [65:64], zero [71:66]
  output logic [rrtsm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status [2:0]
  output logic [rrtsm_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  import rrtsm_pkg::*;

  localparam int SRC_W     = $clog2(SOURCES);
  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W     = CNT_W + 1;
  localparam int ADDR_W    = SRC_W + PTR_W;
  localparam int MEM_DEPTH = SOURCES * (2 ** PTR_W);
  localparam int META_W    = PTR_W + CNT_W;
  localparam int TAG_SHIFT = WORD_WIDTH - HEADER_BITS;

  localparam logic [PTR_W-1:0] HEAD_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(QUEUE_DEPTH);
  localparam logic [SRC_W-1:0] SRC_LAST  = SRC_W'(SOURCES - 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_META = 2'd2;
  localparam logic [1:0] S_DATA = 2'd3;

  logic [1:0]            state_q, state_d;
  logic                  cmd_q, has_q;
  logic [WORD_WIDTH-1:0] word_q;
  logic [SRC_W-1:0]      slot_q, slot_d;
  logic [SRC_W-1:0]      grant_q, grant_d;
  logic [SOURCES-1:0]    nonempty_q, nonempty_d;
  logic [SRC_W-1:0]      src_q, src_d;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [MERGED_W-1:0]   out_word_q, out_word_d;
  logic [SRC_TAG_W-1:0]  out_src_q, out_src_d;

  // Word memory, one row of 2**PTR_W entries per source.
  logic [WORD_WIDTH-1:0] store_mem [MEM_DEPTH];
  logic [WORD_WIDTH-1:0] store_rd_q;
  logic                  store_we, store_re;
  logic [ADDR_W-1:0]     store_waddr, store_raddr;

  // Metadata memory: head in the upper bits, fill count in the lower bits.
  logic [META_W-1:0]     meta_mem [SOURCES];
  logic [META_W-1:0]     meta_rd_q;
  logic [META_W-1:0]     meta_wdata;
  logic                  meta_we, meta_re;
  logic [SRC_W-1:0]      meta_raddr;

  logic                  accept;
  logic                  out_free;
  logic                  pick_found;
  logic [SRC_W-1:0]      pick_idx;
  logic [PTR_W-1:0]      head_eff, head_next;
  logic [CNT_W-1:0]      fill_eff;
  logic [SUM_W-1:0]      pos_sum;
  logic [PTR_W-1:0]      pos_wr;
  logic [WORD_WIDTH-1:0] tagged_word;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  // Round-robin pick among the non-empty FIFOs.
  rrtsm_scan #(
    .SOURCES(SOURCES),
    .SRC_W  (SRC_W)
  ) u_scan (
    .req_i  (nonempty_q),
    .start_i(grant_q),
    .found_o(pick_found),
    .idx_o  (pick_idx)
  );

  // Metadata of an empty FIFO reads as zero.
  assign head_eff = nonempty_q[src_q] ? meta_rd_q[META_W-1:CNT_W] : '0;
  assign fill_eff = nonempty_q[src_q] ? meta_rd_q[CNT_W-1:0] : '0;

  // Write position wraps once at most, since head stays below the depth and fill does not exceed it.
  assign pos_sum = SUM_W'(head_eff) + SUM_W'(fill_eff);
  assign pos_wr  = (pos_sum >= SUM_W'(QUEUE_DEPTH))
                   ? PTR_W'(pos_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(pos_sum);
  assign head_next = (head_eff == HEAD_LAST) ? '0 : head_eff + PTR_W'(1);

  // Source tag in the header position; bits above the word width fall off.
  assign tagged_word = store_rd_q | (WORD_WIDTH'(src_q) << TAG_SHIFT);

  // Request sequencer.
  always_comb begin
    state_d      = state_q;
    slot_d       = slot_q;
    grant_d      = grant_q;
    nonempty_d   = nonempty_q;
    src_d        = src_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_word_d   = out_word_q;
    out_src_d    = out_src_q;
    meta_re      = 1'b0;
    meta_raddr   = slot_q;
    meta_we      = 1'b0;
    meta_wdata   = '0;
    store_we     = 1'b0;
    store_waddr  = {src_q, pos_wr};
    store_re     = 1'b0;
    store_raddr  = {src_q, head_eff};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (!cmd_q && !has_q) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = ST_NODATA;
            out_word_d   = '0;
            out_src_d    = '0;
            slot_d       = (slot_q == SRC_LAST) ? '0 : slot_q + SRC_W'(1);
            state_d      = S_IDLE;
          end
        end else if (cmd_q && (slot_q != '0 || !pick_found)) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_status_d = (slot_q != '0) ? ST_ORDER : ST_EMPTY;
            out_word_d   = '0;
            out_src_d    = '0;
            state_d      = S_IDLE;
          end
        end else begin
          src_d      = cmd_q ? pick_idx : slot_q;
          meta_re    = 1'b1;
          meta_raddr = cmd_q ? pick_idx : slot_q;
          state_d    = S_META;
        end
      end

      S_META: begin
        if (!cmd_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_word_d  = '0;
            out_src_d   = '0;
            if (fill_eff == FILL_FULL) begin
              out_status_d = ST_DROPPED;
            end else begin
              out_status_d      = ST_STORED;
              store_we          = 1'b1;
              meta_we           = 1'b1;
              meta_wdata        = {head_eff, fill_eff + CNT_W'(1)};
              nonempty_d[src_q] = 1'b1;
            end
            slot_d  = (slot_q == SRC_LAST) ? '0 : slot_q + SRC_W'(1);
            state_d = S_IDLE;
          end
        end else begin
          store_re          = 1'b1;
          meta_we           = 1'b1;
          meta_wdata        = {head_next, fill_eff - CNT_W'(1)};
          nonempty_d[src_q] = (fill_eff != CNT_W'(1));
          grant_d           = (grant_q == SRC_LAST) ? '0 : grant_q + SRC_W'(1);
          state_d           = S_DATA;
        end
      end

      S_DATA: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_MERGED;
          out_word_d   = MERGED_W'(tagged_word);
          out_src_d    = SRC_TAG_W'(src_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slot_q      <= '0;
      grant_q     <= '0;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      grant_q     <= grant_d;
      nonempty_q  <= nonempty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= s_axis_tuser[0];
      has_q  <= s_axis_tuser[1];
      word_q <= s_axis_tdata[WORD_WIDTH-1:0];
    end
    src_q        <= src_d;
    out_status_q <= out_status_d;
    out_word_q   <= out_word_d;
    out_src_q    <= out_src_d;
  end

  // Word memory; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_waddr] <= word_q;
    end
    if (store_re) begin
      store_rd_q <= store_mem[store_raddr];
    end
  end

  // Metadata memory; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[src_q] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rd_q <= meta_mem[meta_raddr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{M_PAD_W{1'b0}}, out_src_q, out_word_q};
  assign m_axis_tuser  = out_status_q;

endmodule

`default_nettype wire

[rtl/core/rrtsm_scan.sv]
// ---------------------------------------------------------------------------
// Rotating priority scan
// Finds the first requesting source at or after the start index, wrapping
// around over all sources.
// ---------------------------------------------------------------------------
`default_nettype none

module rrtsm_scan #(
  parameter int SOURCES = 4,
  parameter int SRC_W   = 2
) (
  input  logic [SOURCES-1:0] req_i,
  input  logic [SRC_W-1:0]   start_i,
  output logic               found_o,
  output logic [SRC_W-1:0]   idx_o
);

  localparam int CAND_W = SRC_W + 1;

  // Walk from the farthest candidate to the nearest so the nearest wins.
  always_comb begin
    logic [CAND_W-1:0] cand;
    found_o = 1'b0;
    idx_o   = '0;
    for (int k = SOURCES - 1; k >= 0; k--) begin
      cand = CAND_W'(start_i) + CAND_W'(k);
      if (cand >= CAND_W'(SOURCES)) begin
        cand = cand - CAND_W'(SOURCES);
      end
      if (req_i[cand[SRC_W-1:0]]) begin
        found_o = 1'b1;
        idx_o   = cand[SRC_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/rrtsm_checker.sv]
// ---------------------------------------------------------------------------
// Round-robin tagged stream merger port checker
// Watches the stream ports of the merger over time and reports slips.
// ---------------------------------------------------------------------------
`default_nettype none

module rrtsm_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // merged_word [63:0], source_index [65:64], zero [71:66]
  input  logic [rrtsm_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status [2:0]
  input  logic [rrtsm_pkg::M_TUSER_W-1:0] m_axis_tuser
);

  import rrtsm_pkg::*;

  // A result that was not taken stays, unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed or vanished while stalled");

  // Only defined status codes leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      m_axis_tuser == ST_STORED || m_axis_tuser == ST_NODATA ||
      m_axis_tuser == ST_DROPPED || m_axis_tuser == ST_MERGED ||
      m_axis_tuser == ST_EMPTY || m_axis_tuser == ST_ORDER)
    else $error("undefined status code on the output");

  // Word and source index are zero unless a word was merged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_MERGED |-> m_axis_tdata == '0)
    else $error("payload not zero on a non-merge result");

  // One request at a time: a taken request closes the input in the cycle after it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second request taken while one is in progress");

endmodule

bind round_robin_tagged_stream_merger rrtsm_checker u_rrtsm_checker (.*);

`default_nettype wire
